FILE: src/rob_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rob_pkg: shared types and codes of the ordered reorder buffer
// Beat structs of both channels, action and status codes, configuration register indexes,
// sequencer states and scan modes.
package rob_pkg;

  // input beat
  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  channel;
    logic [63:0] seq;
    logic [15:0] handle;
    logic [15:0] length;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [1:0]  out_channel;
    logic [63:0] out_seq;
    logic [15:0] out_handle;
    logic [15:0] out_length;
    logic [1:0]  status;
    logic [63:0] next_expected;
    logic        last;
  } out_beat_t;

  // action codes
  localparam logic [1:0] ACT_MSG   = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_SWEEP = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_GAP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_DUP  = 2'd3;

  // configuration register indexes
  localparam logic CFG_BACKJUMP = 1'b0;
  localparam logic CFG_STALL    = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_HIT,
    S_FINAL
  } state_t;

  // what a scan of a channel's hold slots looks for
  typedef enum logic [1:0] {
    M_DRAIN,
    M_FIND,
    M_MIN
  } mode_t;

endpackage

FILE: src/ordered_reorder_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_reorder_buffer: per-channel in-order delivery engine
// Holds out-of-order messages per channel and releases them in sequence.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat is a message, a tick or a stall sweep of a channel.
//   out_* : one beat per delivered, dropped or duplicate message; last marks
//           the final result caused by an input beat.
//   cfg_* : write port for restart_backjump (0) and stall_ticks (1).
// Timing: one item at a time. A tick is handled in the idle state. A message or
//   sweep passes the decide and final states plus one scan of the channel's
//   HOLD_MAX slots (serialized by the single read port of the hold memory) per
//   lookup: an out-of-order message does one lookup, an in-order message one per
//   drained entry plus one, a skipping sweep one more for the minimum search.
// Reset: all channels unstarted, buffers empty, tick counter zero, registers
//   back to 256 and 1000. No clearing pass is needed.
// Receiver stall: a result waits in the output register; the sequencer waits
//   when it has a further result to hand over, and in_stall stays high.
// ----------------------------------------------------------------------------
module ordered_reorder_buffer #(
  parameter int CHANNELS = 4,
  parameter int HOLD_MAX = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  rob_pkg::in_beat_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rob_pkg::out_beat_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW  = (HOLD_MAX > 1) ? $clog2(HOLD_MAX) : 1;
  localparam int NV  = CHANNELS * HOLD_MAX;
  localparam int AW  = (NV > 1) ? $clog2(NV) : 1;
  localparam int CNW = $clog2(HOLD_MAX + 1);
  localparam int MW  = 96;

  // configuration and time
  logic [31:0] backjump;
  logic [31:0] stall_ticks;
  logic [31:0] time_now;

  // per-channel state
  logic          started  [CHANNELS];
  logic [63:0]   cursor   [CHANNELS];
  logic          armed    [CHANNELS];
  logic [31:0]   ptime    [CHANNELS];
  logic [CNW-1:0] count   [CHANNELS];
  logic [NV-1:0] held_valid;

  // sequencer
  rob_pkg::state_t state, state_next;
  rob_pkg::mode_t  mode;
  rob_pkg::in_beat_t it;
  logic [CW-1:0]   ch;
  logic [SW:0]     scan_slot;
  logic [SW-1:0]   chk_slot;
  logic            chk_live;
  logic [63:0]     min_seq;
  logic            min_found;
  logic [1:0]      drain_st;
  logic [SW-1:0]   hit_slot;
  logic [63:0]     hit_seq;
  logic [31:0]     hit_pay;
  rob_pkg::out_beat_t pend;
  logic            pend_valid;

  // memory signals
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [MW-1:0] mem_rdata;
  logic [63:0]   rd_seq;
  logic [31:0]   rd_pay;

  rob_hold_mem #(.DEPTH(NV), .AW(AW), .W(MW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_seq = mem_rdata[95:32];
  assign rd_pay = mem_rdata[31:0];

  // current channel view
  logic [31:0]    base;
  logic [HOLD_MAX-1:0] chv;
  logic           c_started, c_armed;
  logic [63:0]    c_cursor;
  logic [CNW-1:0] c_count;
  logic [31:0]    elapsed;

  assign base      = 32'(ch) * HOLD_MAX;
  assign c_started = started[ch];
  assign c_armed   = armed[ch];
  assign c_cursor  = cursor[ch];
  assign c_count   = count[ch];
  assign elapsed   = time_now - ptime[ch];

  always_comb begin
    for (int i = 0; i < HOLD_MAX; i++) begin
      chv[i] = held_valid[AW'(base + 32'(i))];
    end
  end

  // first free slot of the channel
  logic [SW-1:0] free_slot;
  always_comb begin
    free_slot = '0;
    for (int i = HOLD_MAX - 1; i >= 0; i--) begin
      if (!chv[i]) begin
        free_slot = SW'(i);
      end
    end
  end

  // message decision
  logic [63:0] eff_cur, diff;
  logic        behind, near, d_dup, d_restart, d_adopt, d_deliver, d_gap, d_hold;
  always_comb begin
    eff_cur   = c_started ? c_cursor : ((it.seq >= {32'd0, backjump}) ? it.seq : 64'd0);
    behind    = it.seq < eff_cur;
    diff      = eff_cur - it.seq;
    near      = diff < {32'd0, backjump};
    d_dup     = behind && near;
    d_restart = behind && !near;
    d_adopt   = !behind && (it.seq != eff_cur) && c_armed;
    d_gap     = d_restart || d_adopt;
    d_deliver = d_gap || (it.seq == eff_cur);
    d_hold    = !d_dup && !d_deliver && (c_count < CNW'(HOLD_MAX));
  end

  // sweep decision
  logic w_act, w_arm;
  assign w_act = c_started && (elapsed >= stall_ticks);
  assign w_arm = (c_count == '0);

  // scan checks
  logic out_free, issue, chk_ok, hit_drain, hit_find, scan_done, min_upd, in_go;
  assign out_free  = !out_valid || !out_stall;
  assign issue     = (state == rob_pkg::S_SCAN) && (scan_slot < (SW+1)'(HOLD_MAX));
  assign chk_ok    = chk_live && chv[chk_slot];
  assign hit_drain = chk_ok && (mode == rob_pkg::M_DRAIN) && (rd_seq == c_cursor);
  assign hit_find  = chk_ok && (mode == rob_pkg::M_FIND) && (rd_seq == it.seq);
  assign min_upd   = chk_ok && (mode == rob_pkg::M_MIN) && (!min_found || rd_seq < min_seq);
  assign scan_done = (scan_slot == (SW+1)'(HOLD_MAX)) && !chk_live;
  assign in_go     = ((in_data.action == rob_pkg::ACT_MSG) ||
                      (in_data.action == rob_pkg::ACT_SWEEP)) &&
                     (32'(in_data.channel) < CHANNELS);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rob_pkg::S_IDLE: begin
        if (in_valid && in_go) state_next = rob_pkg::S_DECIDE;
      end
      rob_pkg::S_DECIDE: begin
        if (it.action == rob_pkg::ACT_MSG) begin
          state_next = (d_deliver || d_hold) ? rob_pkg::S_SCAN : rob_pkg::S_FINAL;
        end else begin
          state_next = (w_act && !w_arm) ? rob_pkg::S_SCAN : rob_pkg::S_FINAL;
        end
      end
      rob_pkg::S_SCAN: begin
        if (hit_drain) begin
          state_next = rob_pkg::S_HIT;
        end else if (hit_find) begin
          state_next = rob_pkg::S_FINAL;
        end else if (scan_done) begin
          state_next = (mode == rob_pkg::M_MIN && min_found) ? rob_pkg::S_SCAN
                                                             : rob_pkg::S_FINAL;
        end
      end
      rob_pkg::S_HIT: begin
        if (!pend_valid || out_free) state_next = rob_pkg::S_SCAN;
      end
      rob_pkg::S_FINAL: begin
        if (!pend_valid || out_free) state_next = rob_pkg::S_IDLE;
      end
      default: state_next = rob_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall  = (state != rob_pkg::S_IDLE);
    mem_re    = issue;
    mem_raddr = AW'(base + 32'(scan_slot[SW-1:0]));
    mem_we    = (state == rob_pkg::S_SCAN) && scan_done && (mode == rob_pkg::M_FIND);
    mem_waddr = AW'(base + 32'(free_slot));
    mem_wdata = {it.seq, it.handle, it.length};
  end

  // registers and per-channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rob_pkg::S_IDLE;
      backjump    <= 32'd256;
      stall_ticks <= 32'd1000;
      time_now    <= '0;
      held_valid  <= '0;
      out_valid   <= 1'b0;
      pend_valid  <= 1'b0;
      chk_live    <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        started[c] <= 1'b0;
        cursor[c]  <= '0;
        armed[c]   <= 1'b0;
        ptime[c]   <= '0;
        count[c]   <= '0;
      end
    end else begin
      state <= state_next;

      // configuration writes
      if (cfg_we) begin
        if (cfg_index == rob_pkg::CFG_BACKJUMP) backjump <= cfg_data;
        else                                   stall_ticks <= cfg_data;
      end

      // output register drains when taken
      if (out_valid && !out_stall) out_valid <= 1'b0;

      case (state)
        rob_pkg::S_IDLE: begin
          if (in_valid) begin
            it <= in_data;
            ch <= CW'(32'(in_data.channel));
            if (in_data.action == rob_pkg::ACT_TICK) time_now <= time_now + 32'd1;
          end
        end

        rob_pkg::S_DECIDE: begin
          scan_slot <= '0;
          chk_live  <= 1'b0;
          min_found <= 1'b0;
          if (it.action == rob_pkg::ACT_MSG) begin
            started[ch] <= 1'b1;
            cursor[ch]  <= eff_cur;
            if (!c_started) ptime[ch] <= time_now;
            pend.out_channel   <= it.channel;
            pend.out_seq       <= it.seq;
            pend.out_handle    <= it.handle;
            pend.out_length    <= it.length;
            pend.next_expected <= eff_cur;
            pend.last          <= 1'b0;
            if (d_dup) begin
              pend.status <= rob_pkg::ST_DUP;
              pend_valid  <= 1'b1;
            end else if (d_deliver) begin
              if (d_restart) begin
                for (int i = 0; i < HOLD_MAX; i++) begin
                  held_valid[AW'(base + 32'(i))] <= 1'b0;
                end
                count[ch] <= '0;
              end
              cursor[ch]         <= it.seq + 64'd1;
              pend.next_expected <= it.seq + 64'd1;
              pend.status        <= d_gap ? rob_pkg::ST_GAP : rob_pkg::ST_OK;
              pend_valid         <= 1'b1;
              ptime[ch]          <= time_now;
              armed[ch]          <= 1'b0;
              mode               <= rob_pkg::M_DRAIN;
              drain_st           <= rob_pkg::ST_OK;
            end else if (d_hold) begin
              mode <= rob_pkg::M_FIND;
            end else begin
              pend.status <= rob_pkg::ST_FULL;
              pend_valid  <= 1'b1;
            end
          end else if (w_act) begin
            if (w_arm) begin
              armed[ch] <= 1'b1;
              ptime[ch] <= time_now;
            end else begin
              mode <= rob_pkg::M_MIN;
            end
          end
        end

        rob_pkg::S_SCAN: begin
          chk_live <= issue;
          if (issue) begin
            scan_slot <= scan_slot + 1'b1;
            chk_slot  <= scan_slot[SW-1:0];
          end
          if (min_upd) begin
            min_seq   <= rd_seq;
            min_found <= 1'b1;
          end
          if (hit_drain) begin
            hit_slot <= chk_slot;
            hit_seq  <= rd_seq;
            hit_pay  <= rd_pay;
          end else if (scan_done) begin
            if (mode == rob_pkg::M_MIN && min_found) begin
              cursor[ch] <= min_seq;
              ptime[ch]  <= time_now;
              armed[ch]  <= 1'b0;
              mode       <= rob_pkg::M_DRAIN;
              drain_st   <= rob_pkg::ST_GAP;
              scan_slot  <= '0;
            end else if (mode == rob_pkg::M_FIND) begin
              held_valid[AW'(base + 32'(free_slot))] <= 1'b1;
              count[ch] <= c_count + 1'b1;
            end
          end
        end

        rob_pkg::S_HIT: begin
          chk_live <= 1'b0;
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              out_data  <= pend;
              out_valid <= 1'b1;
            end
            pend.out_channel   <= it.channel;
            pend.out_seq       <= hit_seq;
            pend.out_handle    <= hit_pay[31:16];
            pend.out_length    <= hit_pay[15:0];
            pend.status        <= drain_st;
            pend.next_expected <= c_cursor + 64'd1;
            pend.last          <= 1'b0;
            pend_valid         <= 1'b1;
            drain_st           <= rob_pkg::ST_OK;
            cursor[ch]         <= c_cursor + 64'd1;
            held_valid[AW'(base + 32'(hit_slot))] <= 1'b0;
            count[ch]          <= c_count - 1'b1;
            scan_slot          <= '0;
          end
        end

        rob_pkg::S_FINAL: begin
          chk_live <= 1'b0;
          if (pend_valid && out_free) begin
            out_data      <= pend;
            out_data.last <= 1'b1;
            out_valid     <= 1'b1;
            pend_valid    <= 1'b0;
          end
        end

        default: ;
      endcase
    end
  end

  // fill count tracks the valid bits of the channel in service
  assert property (@(posedge clk) disable iff (rst)
    32'(c_count) == 32'($countones(chv)))
    else $error("fill count disagrees with valid bits");

  // fill count never exceeds the slots of a channel
  assert property (@(posedge clk) disable iff (rst)
    c_count <= CNW'(HOLD_MAX))
    else $error("fill count overflow");

  // no result is left pending once the item is finished
  assert property (@(posedge clk) disable iff (rst)
    (state == rob_pkg::S_IDLE) |-> !pend_valid)
    else $error("pending result in idle");

  // a drain hit leads to the handover state
  assert property (@(posedge clk) disable iff (rst)
    (state == rob_pkg::S_SCAN && hit_drain) |=> (state == rob_pkg::S_HIT))
    else $error("drain hit not handed over");

endmodule

FILE: src/rob_hold_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rob_hold_mem: hold slot storage
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rob_hold_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int W     = 96
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
